// ===== hw/rtl/bitmap_font_text_renderer_unit_assert.svh =====
`ifndef BITMAP_FONT_TEXT_RENDERER_UNIT_ASSERT_SVH
`define BITMAP_FONT_TEXT_RENDERER_UNIT_ASSERT_SVH

// check cond in the same cycle as trig
`define BFTR_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("bftr assertion failed");

// check cond in the cycle after trig
`define BFTR_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("bftr assertion failed");

`endif

// ===== hw/rtl/bftr_pkg.sv =====
package bftr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IDX_W      = 33;
  localparam int BASE_W     = 14;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_STRIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd5;

  localparam logic [1:0] CMD_DRAW = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_HOME = 2'd2;

  localparam logic [15:0] RST_SCREEN_WIDTH = 16'd640;
  localparam logic [15:0] RST_LINE_PITCH   = 16'd640;
  localparam logic [5:0]  RST_GLYPH_STRIDE = 6'd16;
  localparam logic [31:0] RST_DRAW_COLOUR  = 32'hFFFF_FFFF;
  localparam logic [15:0] RST_ORIGIN_X     = 16'd50;
  localparam logic [15:0] RST_ORIGIN_Y     = 16'd120;

  localparam logic [16:0] GLYPH_WIDTH = 17'd8;

  typedef struct packed {
    logic glyph_write;
    logic cursor_home;
    logic draw_setup;
    logic row_start;
    logic row_emit;
    logic cursor_step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic row_last;
  } dp_sts_t;

endpackage

// ===== hw/rtl/bftr_if.sv =====
interface bftr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  char_code;
  logic [12:0] glyph_address;
  logic [7:0]  glyph_byte;

  modport source (output valid, command, char_code, glyph_address, glyph_byte,
                  input ready);
  modport sink (input valid, command, char_code, glyph_address, glyph_byte,
                output ready);
endinterface

interface bftr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_index;
  logic [7:0]  row_mask;
  logic [31:0] pixel_colour;
  logic        index_overflow;
  logic        last_row;

  modport source (output valid, pixel_index, row_mask, pixel_colour, index_overflow,
                  last_row, input ready);
  modport sink (input valid, pixel_index, row_mask, pixel_colour, index_overflow,
                last_row, output ready);
endinterface

// ===== hw/rtl/bftr_ram.sv =====
module bftr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/bftr_ctrl.sv =====
module bftr_ctrl import bftr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  input  logic       in_code_zero,
  output logic       in_ready,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.glyph_write = accept && (in_command == CMD_LOAD);
        cmd.cursor_home = accept && (in_command == CMD_HOME);
        cmd.draw_setup  = accept && (in_command == CMD_DRAW) && !in_code_zero;
        if (cmd.draw_setup) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.row_start = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.row_emit = 1'b1;
          if (sts.row_last) begin
            cmd.cursor_step = 1'b1;
            state_nxt       = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/bftr_dp.sv =====
module bftr_dp import bftr_pkg::*; #(
  parameter int GLYPH_STORE_BYTES = 8192,
  parameter int GLYPH_ROWS        = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [7:0]            char_code,
  input  logic [12:0]           glyph_address,
  input  logic [7:0]            glyph_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           pixel_index,
  output logic [7:0]            row_mask,
  output logic [31:0]           pixel_colour,
  output logic                  index_overflow,
  output logic                  last_row
);

  localparam int AW = $clog2(GLYPH_STORE_BYTES);
  localparam int RW = $clog2(GLYPH_ROWS);

  logic [15:0]       screen_width_r;
  logic [15:0]       line_pitch_r;
  logic [5:0]        glyph_stride_r;
  logic [31:0]       draw_colour_r;
  logic [15:0]       origin_x_r;
  logic [15:0]       origin_y_r;
  logic [15:0]       cursor_x_r;
  logic [15:0]       cursor_y_r;
  logic [BASE_W-1:0] base_r;
  logic [31:0]       prod_r;
  logic [IDX_W-1:0]  idx_r;
  logic [RW-1:0]     row_r;
  logic              out_valid_r;
  logic [31:0]       pixel_index_r;
  logic [7:0]        row_mask_r;
  logic [31:0]       pixel_colour_r;
  logic              index_overflow_r;
  logic              last_row_r;

  logic [16:0]   x_plus8_w;
  logic [16:0]   x_plus16_w;
  logic [RW:0]   row_inc_w;
  logic [RW:0]   row_sel_w;
  logic [16:0]   raddr_full_w;
  logic [15:0]   waddr_full_w;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r <= RST_SCREEN_WIDTH;
      line_pitch_r   <= RST_LINE_PITCH;
      glyph_stride_r <= RST_GLYPH_STRIDE;
      draw_colour_r  <= RST_DRAW_COLOUR;
      origin_x_r     <= RST_ORIGIN_X;
      origin_y_r     <= RST_ORIGIN_Y;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH: screen_width_r <= cfg_wdata[15:0];
        REG_LINE_PITCH:   line_pitch_r   <= cfg_wdata[15:0];
        REG_GLYPH_STRIDE: glyph_stride_r <= cfg_wdata[5:0];
        REG_DRAW_COLOUR:  draw_colour_r  <= cfg_wdata;
        REG_ORIGIN_X:     origin_x_r     <= cfg_wdata[15:0];
        REG_ORIGIN_Y:     origin_y_r     <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign x_plus8_w  = {1'b0, cursor_x_r} + GLYPH_WIDTH;
  assign x_plus16_w = x_plus8_w + GLYPH_WIDTH;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= RST_ORIGIN_X;
      cursor_y_r <= RST_ORIGIN_Y;
    end else if (cmd.cursor_home) begin
      cursor_x_r <= origin_x_r;
      cursor_y_r <= origin_y_r;
    end else if (cmd.cursor_step) begin
      if (x_plus16_w > {1'b0, screen_width_r}) begin
        cursor_x_r <= '0;
        cursor_y_r <= cursor_y_r + 16'(GLYPH_ROWS);
      end else begin
        cursor_x_r <= x_plus8_w[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_setup) begin
      base_r <= BASE_W'(char_code) * BASE_W'(glyph_stride_r);
      prod_r <= 32'(cursor_y_r) * 32'(line_pitch_r);
    end
    if (cmd.row_start) begin
      idx_r <= IDX_W'(prod_r) + IDX_W'(cursor_x_r);
    end else if (cmd.row_emit) begin
      idx_r <= idx_r + IDX_W'(line_pitch_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (cmd.row_start) begin
      row_r <= '0;
    end else if (cmd.row_emit) begin
      row_r <= row_inc_w[RW-1:0];
    end
  end

  assign row_inc_w    = {1'b0, row_r} + (RW + 1)'(1);
  assign row_sel_w    = cmd.row_start ? '0 : row_inc_w;
  assign raddr_full_w = 17'(base_r) + 17'(row_sel_w);
  assign waddr_full_w = 16'(glyph_address);
  assign ram_re       = cmd.row_start || (cmd.row_emit && !sts.row_last);

  bftr_ram #(
    .WIDTH (8),
    .DEPTH (GLYPH_STORE_BYTES)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (cmd.glyph_write),
    .waddr (waddr_full_w[AW-1:0]),
    .wdata (glyph_byte),
    .re    (ram_re),
    .raddr (raddr_full_w[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.row_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_emit) begin
      pixel_index_r    <= idx_r[31:0];
      row_mask_r       <= ram_rdata;
      pixel_colour_r   <= draw_colour_r;
      index_overflow_r <= idx_r[IDX_W-1];
      last_row_r       <= sts.row_last;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.row_last = (row_r == RW'(GLYPH_ROWS - 1));

  assign out_valid      = out_valid_r;
  assign pixel_index    = pixel_index_r;
  assign row_mask       = row_mask_r;
  assign pixel_colour   = pixel_colour_r;
  assign index_overflow = index_overflow_r;
  assign last_row       = last_row_r;

endmodule

// ===== hw/rtl/bitmap_font_text_renderer_unit.sv =====
// Channel   Dir   Carries
// in_ch     in    command, char_code, glyph_address, glyph_byte
// out_ch    out   pixel_index, row_mask, pixel_colour, index_overflow, last_row
// cfg_*     in    register write: cfg_we, cfg_index, cfg_wdata
//
// Load, home, unused commands and draws of code zero complete on acceptance.
// A draw steps through accept, first glyph store read, then one row per cycle
// while the output is free, paced by the single read port of the glyph store.
// Reset is synchronous; the glyph store holds no reset value.
// A stalled output holds the row in the output register and pauses the reads.
module bitmap_font_text_renderer_unit import bftr_pkg::*; #(
  parameter int GLYPH_STORE_BYTES = 8192,
  parameter int GLYPH_ROWS        = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bftr_in_if.sink               in_ch,
  bftr_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bftr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_command   (in_ch.command),
    .in_code_zero (in_ch.char_code == 8'd0),
    .in_ready     (in_ch.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  bftr_dp #(
    .GLYPH_STORE_BYTES (GLYPH_STORE_BYTES),
    .GLYPH_ROWS        (GLYPH_ROWS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .char_code      (in_ch.char_code),
    .glyph_address  (in_ch.glyph_address),
    .glyph_byte     (in_ch.glyph_byte),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .pixel_index    (out_ch.pixel_index),
    .row_mask       (out_ch.row_mask),
    .pixel_colour   (out_ch.pixel_colour),
    .index_overflow (out_ch.index_overflow),
    .last_row       (out_ch.last_row)
  );

endmodule

// ===== hw/rtl/bftr_checker.sv =====
`include "bitmap_font_text_renderer_unit_assert.svh"

module bftr_checker import bftr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_command,
  input logic [7:0]  in_char_code,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel_index,
  input logic [7:0]  out_row_mask
);

  logic in_acc;
  logic draw_acc;
  logic out_stall;

  assign in_acc    = in_valid && in_ready;
  assign draw_acc  = in_acc && (in_command == CMD_DRAW) && (in_char_code != 8'd0);
  assign out_stall = out_valid && !out_ready;

  `BFTR_ASSERT_NEXT(a_out_hold, out_stall, out_valid)
  `BFTR_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_pixel_index) && $stable(out_row_mask))
  `BFTR_ASSERT_NEXT(a_draw_busy, draw_acc, !in_ready && !in_acc)
  `BFTR_ASSERT_NEXT(a_short_cmd, in_acc && !draw_acc, in_ready)
  `BFTR_ASSERT_NEXT(a_no_early_row, draw_acc, !out_valid || $past(out_valid))

endmodule

bind bitmap_font_text_renderer_unit bftr_checker u_bftr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_command      (in_ch.command),
  .in_char_code    (in_ch.char_code),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pixel_index (out_ch.pixel_index),
  .out_row_mask    (out_ch.row_mask)
);
